// ===== hdl/tdcs_pkg.sv =====
package tdcs_pkg;

   localparam int TF_W     = 32;
   localparam int CL_W     = 40;
   localparam int DL_W     = 32;
   localparam int PROD_W   = TF_W + CL_W;
   localparam int FRAC_W   = 16;
   localparam int DIVD_W   = PROD_W + FRAC_W;
   localparam int CNT_W    = 7;
   localparam int M_W      = 32;
   localparam int LG_W     = 23;
   localparam int K_W      = 31;
   localparam int V_W      = 22;
   localparam int SUM_W    = 27;
   localparam int CSR_A_W  = 5;
   localparam int CSR_D_W  = 64;

   localparam logic [K_W-1:0]   LOG10_2_Q32 = 31'd1292913986;
   localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};

   localparam logic [1:0] REG_COLL_LEN_TITLE = 2'd0;
   localparam logic [1:0] REG_COLL_LEN_BODY  = 2'd1;
   localparam logic [1:0] REG_COLL_LEN_WHOLE = 2'd2;

   typedef enum logic [2:0] {
      U_IDLE, U_MUL, U_PREP, U_DIV, U_ADDX, U_NORM, U_LOG, U_SCALE
   } unit_state_type;

   typedef enum logic [1:0] {
      T_IDLE, T_BUSY, T_ACC
   } top_state_type;

   typedef struct packed {
      logic [TF_W-1:0] tf;
      logic [CL_W-1:0] ctf;
      logic [CL_W-1:0] cl;
      logic [DL_W-1:0] dl;
   } term_op_type;

endpackage

// ===== hdl/tdcs_if.sv =====
interface tdcs_req_if import tdcs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TF_W-1:0]   term_freq;
   logic [CL_W-1:0]   coll_term_freq;
   logic              is_title;
   logic [DL_W-1:0]   doc_len_title;
   logic [DL_W-1:0]   doc_len_body;
   logic [DL_W-1:0]   doc_len_whole;
   logic              last_term;

   modport source (output valid, term_freq, coll_term_freq, is_title, doc_len_title,
                   doc_len_body, doc_len_whole, last_term, input ready);
   modport sink (input valid, term_freq, coll_term_freq, is_title, doc_len_title,
                 doc_len_body, doc_len_whole, last_term, output ready);
endinterface

interface tdcs_rsp_if import tdcs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SUM_W-1:0]  title_score;
   logic [SUM_W-1:0]  body_score;
   logic [SUM_W-1:0]  whole_score;

   modport source (output valid, title_score, body_score, whole_score, input ready);
   modport sink (input valid, title_score, body_score, whole_score, output ready);
endinterface

// ===== hdl/tdcs_term_unit.sv =====
module tdcs_term_unit import tdcs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  term_op_type     op,
   output logic            done,
   output logic [V_W-1:0]  value
);

   unit_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TF_W-1:0]    mpl_n_ff, mpl_n_in;
   logic [DL_W-1:0]    mpl_d_ff, mpl_d_in;
   logic [CL_W-1:0]    mcd_n_ff, mcd_n_in;
   logic [CL_W-1:0]    mcd_d_ff, mcd_d_in;
   logic [PROD_W-1:0]  prod_n_ff, prod_n_in;
   logic [PROD_W-1:0]  prod_d_ff, prod_d_in;
   logic [DIVD_W-1:0]  divd_ff, divd_in;
   logic [PROD_W-1:0]  rem_ff, rem_in;
   logic [M_W-1:0]     m_ff, m_in;
   logic [LG_W-1:0]    lg_ff, lg_in;
   logic [V_W-1:0]     value_ff, value_in;
   logic               done_ff, done_in;

   logic [PROD_W:0]    r2;
   logic [PROD_W+1:0]  diff;
   logic [2*M_W-1:0]   sq;
   logic [M_W:0]       t;
   logic [LG_W+K_W-1:0] scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      mpl_n_ff  <= mpl_n_in;
      mpl_d_ff  <= mpl_d_in;
      mcd_n_ff  <= mcd_n_in;
      mcd_d_ff  <= mcd_d_in;
      prod_n_ff <= prod_n_in;
      prod_d_ff <= prod_d_in;
      divd_ff   <= divd_in;
      rem_ff    <= rem_in;
      m_ff      <= m_in;
      lg_ff     <= lg_in;
      value_ff  <= value_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mpl_n_in  = mpl_n_ff;
      mpl_d_in  = mpl_d_ff;
      mcd_n_in  = mcd_n_ff;
      mcd_d_in  = mcd_d_ff;
      prod_n_in = prod_n_ff;
      prod_d_in = prod_d_ff;
      divd_in   = divd_ff;
      rem_in    = rem_ff;
      m_in      = m_ff;
      lg_in     = lg_ff;
      value_in  = value_ff;
      done_in   = 1'b0;
      r2        = {rem_ff, divd_ff[DIVD_W-1]};
      diff      = {1'b0, r2} - {2'b00, prod_d_ff};
      sq        = m_ff * m_ff;
      t         = sq[2*M_W-1:M_W-1];
      scaled    = (LG_W+K_W)'(lg_ff) * (LG_W+K_W)'(LOG10_2_Q32)
                  + (LG_W+K_W)'(64'h8000_0000);
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               mpl_n_in  = op.tf;
               mcd_n_in  = op.cl;
               mpl_d_in  = op.dl;
               mcd_d_in  = op.ctf;
               prod_n_in = '0;
               prod_d_in = '0;
               cnt_in    = '0;
               state_in  = U_MUL;
            end
         end
         U_MUL: begin
            // shift-and-add, multiplier bits msb first
            prod_n_in = {prod_n_ff[PROD_W-2:0], 1'b0}
                        + (mpl_n_ff[TF_W-1] ? PROD_W'(mcd_n_ff) : '0);
            prod_d_in = {prod_d_ff[PROD_W-2:0], 1'b0}
                        + (mpl_d_ff[DL_W-1] ? PROD_W'(mcd_d_ff) : '0);
            mpl_n_in  = {mpl_n_ff[TF_W-2:0], 1'b0};
            mpl_d_in  = {mpl_d_ff[DL_W-2:0], 1'b0};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TF_W - 1)) begin
               state_in = U_PREP;
            end
         end
         U_PREP: begin
            prod_d_in = prod_d_ff + 1'b1;
            divd_in   = {prod_n_ff, {FRAC_W{1'b0}}};
            rem_in    = '0;
            cnt_in    = '0;
            state_in  = U_DIV;
         end
         U_DIV: begin
            // restoring division, one quotient bit per cycle
            if (!diff[PROD_W+1]) begin
               rem_in  = diff[PROD_W-1:0];
               divd_in = {divd_ff[DIVD_W-2:0], 1'b1};
            end else begin
               rem_in  = r2[PROD_W-1:0];
               divd_in = {divd_ff[DIVD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
               state_in = U_ADDX;
            end
         end
         U_ADDX: begin
            divd_in  = divd_ff + (DIVD_W'(1) << FRAC_W);
            cnt_in   = '0;
            state_in = U_NORM;
         end
         U_NORM: begin
            // left-justify, a byte at a time while the top byte is clear, else a bit at a time
            if (divd_ff[DIVD_W-1]) begin
               m_in     = divd_ff[DIVD_W-1 -: M_W];
               lg_in    = LG_W'(CNT_W'(DIVD_W - 1 - FRAC_W) - cnt_ff);
               cnt_in   = '0;
               state_in = U_LOG;
            end else if (divd_ff[DIVD_W-1 -: 8] == 8'd0) begin
               divd_in = {divd_ff[DIVD_W-9:0], 8'd0};
               cnt_in  = cnt_ff + CNT_W'(8);
            end else begin
               divd_in = {divd_ff[DIVD_W-2:0], 1'b0};
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         U_LOG: begin
            // squaring step: one fraction bit of log2 per cycle
            lg_in  = {lg_ff[LG_W-2:0], t[M_W]};
            m_in   = t[M_W] ? t[M_W:1] : t[M_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
               state_in = U_SCALE;
            end
         end
         U_SCALE: begin
            value_in = scaled[32 +: V_W];
            done_in  = 1'b1;
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

// ===== hdl/tf_doclen_colltf_colllen_score.sv =====
// One request per query term. The time from acceptance to the update of the sums is set
// mostly by the 88-step bit-serial restoring division in the term units (plus 32 steps of
// shift-and-add multiplication, the normalising shifts and 16 squaring steps for the
// logarithm). The field and whole-document values are worked
// out side by side in two units. A new request is taken once the previous one has updated
// the sums; a finished result may still wait in the output register meanwhile. Write the
// collection lengths only while the block is idle.
module tf_doclen_colltf_colllen_score import tdcs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tdcs_req_if.sink             req_ch,
   tdcs_rsp_if.source           rsp_ch,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_A_W-1:0]   csr_paddr,
   input  logic [CSR_D_W-1:0]   csr_pwdata,
   output logic [CSR_D_W-1:0]   csr_prdata,
   output logic                 csr_pready
);

   top_state_type      state_ff, state_in;
   logic [CL_W-1:0]    cl_title_ff, cl_body_ff, cl_whole_ff;
   term_op_type        op_f_ff, op_f_in, op_w_ff, op_w_in;
   logic               is_title_ff, is_title_in;
   logic               last_ff, last_in;
   logic               start_ff, start_in;
   logic               done_f_ff, done_f_in, done_w_ff, done_w_in;
   logic [SUM_W-1:0]   title_sum_ff, title_sum_in;
   logic [SUM_W-1:0]   body_sum_ff, body_sum_in;
   logic [SUM_W-1:0]   whole_sum_ff, whole_sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_title_ff, rsp_title_in;
   logic [SUM_W-1:0]   rsp_body_ff, rsp_body_in;
   logic [SUM_W-1:0]   rsp_whole_ff, rsp_whole_in;

   logic               f_done, w_done;
   logic [V_W-1:0]     f_value, w_value;
   logic               req_accept, rsp_accept, csr_write;
   logic [SUM_W:0]     add_title, add_body, add_whole;
   logic [SUM_W-1:0]   new_title, new_body, new_whole;

   tdcs_term_unit u_field (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .op    (op_f_ff),
      .done  (f_done),
      .value (f_value)
   );

   tdcs_term_unit u_whole (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .op    (op_w_ff),
      .done  (w_done),
      .value (w_value)
   );

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_accept = rsp_ch.valid && rsp_ch.ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_title_ff <= '0;
         cl_body_ff  <= '0;
         cl_whole_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[4:3])
            REG_COLL_LEN_TITLE: cl_title_ff <= csr_pwdata[CL_W-1:0];
            REG_COLL_LEN_BODY:  cl_body_ff  <= csr_pwdata[CL_W-1:0];
            REG_COLL_LEN_WHOLE: cl_whole_ff <= csr_pwdata[CL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         REG_COLL_LEN_TITLE: csr_prdata = CSR_D_W'(cl_title_ff);
         REG_COLL_LEN_BODY:  csr_prdata = CSR_D_W'(cl_body_ff);
         REG_COLL_LEN_WHOLE: csr_prdata = CSR_D_W'(cl_whole_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         start_ff     <= 1'b0;
         done_f_ff    <= 1'b0;
         done_w_ff    <= 1'b0;
         title_sum_ff <= '0;
         body_sum_ff  <= '0;
         whole_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         done_f_ff    <= done_f_in;
         done_w_ff    <= done_w_in;
         title_sum_ff <= title_sum_in;
         body_sum_ff  <= body_sum_in;
         whole_sum_ff <= whole_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_f_ff      <= op_f_in;
      op_w_ff      <= op_w_in;
      is_title_ff  <= is_title_in;
      last_ff      <= last_in;
      rsp_title_ff <= rsp_title_in;
      rsp_body_ff  <= rsp_body_in;
      rsp_whole_ff <= rsp_whole_in;
   end

   // saturating sums
   always_comb begin
      add_title = {1'b0, title_sum_ff} + (SUM_W+1)'(f_value);
      add_body  = {1'b0, body_sum_ff} + (SUM_W+1)'(f_value);
      add_whole = {1'b0, whole_sum_ff} + (SUM_W+1)'(w_value);
      new_title = title_sum_ff;
      new_body  = body_sum_ff;
      if (is_title_ff) begin
         new_title = add_title[SUM_W] ? SUM_MAX : add_title[SUM_W-1:0];
      end else begin
         new_body = add_body[SUM_W] ? SUM_MAX : add_body[SUM_W-1:0];
      end
      new_whole = add_whole[SUM_W] ? SUM_MAX : add_whole[SUM_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      op_f_in      = op_f_ff;
      op_w_in      = op_w_ff;
      is_title_in  = is_title_ff;
      last_in      = last_ff;
      start_in     = 1'b0;
      done_f_in    = done_f_ff | f_done;
      done_w_in    = done_w_ff | w_done;
      title_sum_in = title_sum_ff;
      body_sum_in  = body_sum_ff;
      whole_sum_in = whole_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_title_in = rsp_title_ff;
      rsp_body_in  = rsp_body_ff;
      rsp_whole_in = rsp_whole_ff;
      req_ch.ready = 1'b0;
      case (state_ff)
         T_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_accept) begin
               op_f_in.tf  = req_ch.term_freq;
               op_f_in.ctf = req_ch.coll_term_freq;
               op_f_in.cl  = req_ch.is_title ? cl_title_ff : cl_body_ff;
               op_f_in.dl  = req_ch.is_title ? req_ch.doc_len_title : req_ch.doc_len_body;
               op_w_in.tf  = req_ch.term_freq;
               op_w_in.ctf = req_ch.coll_term_freq;
               op_w_in.cl  = cl_whole_ff;
               op_w_in.dl  = req_ch.doc_len_whole;
               is_title_in = req_ch.is_title;
               last_in     = req_ch.last_term;
               start_in    = 1'b1;
               done_f_in   = 1'b0;
               done_w_in   = 1'b0;
               state_in    = T_BUSY;
            end
         end
         T_BUSY: begin
            if (done_f_in && done_w_in) begin
               state_in = T_ACC;
            end
         end
         T_ACC: begin
            if (!last_ff) begin
               title_sum_in = new_title;
               body_sum_in  = new_body;
               whole_sum_in = new_whole;
               state_in     = T_IDLE;
            end else if (!rsp_valid_ff || rsp_accept) begin
               rsp_title_in = new_title;
               rsp_body_in  = new_body;
               rsp_whole_in = new_whole;
               rsp_valid_in = 1'b1;
               title_sum_in = '0;
               body_sum_in  = '0;
               whole_sum_in = '0;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.title_score = rsp_title_ff;
   assign rsp_ch.body_score  = rsp_body_ff;
   assign rsp_ch.whole_score = rsp_whole_ff;

endmodule

// ===== hdl/tdcs_chk.sv =====
module tdcs_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_pready
);

   // a request keeps the block busy for the cycle after it
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after request");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_pready: assert property (@(posedge clock)
      csr_pready)
      else $error("pready low");

endmodule

bind tf_doclen_colltf_colllen_score tdcs_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .csr_pready (csr_pready)
);

// ===== test/tf_doclen_colltf_colllen_score_tb.sv =====
module tf_doclen_colltf_colllen_score_tb;
   import tdcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int LONG_HOLD      = 3000;

   typedef struct {
      bit [TF_W-1:0]  tf;
      bit [CL_W-1:0]  ctf;
      bit             title;
      bit [DL_W-1:0]  dl_title;
      bit [DL_W-1:0]  dl_body;
      bit [DL_W-1:0]  dl_whole;
      bit             last;
   } term_type;

   typedef struct {
      bit [SUM_W-1:0] title;
      bit [SUM_W-1:0] body;
      bit [SUM_W-1:0] whole;
   } scores_type;

   typedef struct {
      term_type   term;
      bit         known;
      scores_type scores;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_psel, csr_penable, csr_pwrite;
   logic [CSR_A_W-1:0]   csr_paddr;
   logic [CSR_D_W-1:0]   csr_pwdata;
   logic [CSR_D_W-1:0]   csr_prdata;
   logic                 csr_pready;

   tdcs_req_if req_ch();
   tdcs_rsp_if rsp_ch();

   tf_doclen_colltf_colllen_score dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // predictor state
   bit [CL_W-1:0]  len_reg [3];
   bit [SUM_W-1:0] title_acc, body_acc, whole_acc;
   scores_type     expected_scores [$];
   bit             pending_known [$];
   scores_type     pending_scores [$];
   int             errors;
   int             src_idle_pct, snk_idle_pct;
   bit             hold_rsp;
   int             quiet_cycles;
   row_type        rows [$];

   function automatic bit [63:0] log_ratio(bit [TF_W-1:0] tf, bit [CL_W-1:0] ctf,
                                           bit [CL_W-1:0] cl, bit [DL_W-1:0] dl);
      bit [127:0] num, den, quot, x;
      bit [63:0]  m, lg;
      int         p;
      num  = ({96'b0, tf} * {88'b0, cl}) << FRAC_W;
      den  = {96'b0, dl} * {88'b0, ctf} + 128'd1;
      quot = num / den;
      x    = quot + 128'h10000;
      p    = 127;
      while (!x[p]) p--;
      if (p >= 31) m = 64'(x >> (p - 31));
      else m = 64'(x << (31 - p));
      lg = 64'(p - FRAC_W);
      for (int i = 0; i < FRAC_W; i++) begin
         m  = (m * m) >> 31;
         lg = lg << 1;
         if (m >= 64'h1_0000_0000) begin
            lg[0] = 1'b1;
            m     = m >> 1;
         end
      end
      return (lg * 64'(LOG10_2_Q32) + 64'h8000_0000) >> 32;
   endfunction

   function automatic bit [SUM_W-1:0] sat_sum(bit [SUM_W-1:0] s, bit [63:0] v);
      bit [63:0] r;
      r = 64'(s) + v;
      return (r > 64'(SUM_MAX)) ? SUM_MAX : r[SUM_W-1:0];
   endfunction

   function automatic bit [63:0] pick(int w);
      bit [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(4, 0))
         0: return 64'd0;
         1: return 64'($urandom_range(1000, 1));
         2: return (64'd1 << w) - 1;
         default: return v & ((64'd1 << w) - 1);
      endcase
   endfunction

   // acceptance, prediction and checking
   always @(posedge clock) begin
      scores_type got, want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.title = rsp_ch.title_score;
            got.body  = rsp_ch.body_score;
            got.whole = rsp_ch.whole_score;
            if (expected_scores.size() == 0) begin
               $display("%0t: unexpected result %h %h %h", $time,
                        got.title, got.body, got.whole);
               errors++;
            end else begin
               want = expected_scores.pop_front();
               if (got.title !== want.title)
                  $display("%0t: title_score expected %h actual %h", $time,
                           want.title, got.title);
               if (got.body !== want.body)
                  $display("%0t: body_score expected %h actual %h", $time,
                           want.body, got.body);
               if (got.whole !== want.whole)
                  $display("%0t: whole_score expected %h actual %h", $time,
                           want.whole, got.whole);
               if (got.title !== want.title || got.body !== want.body ||
                   got.whole !== want.whole) errors++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.is_title)
               title_acc = sat_sum(title_acc, log_ratio(req_ch.term_freq,
                  req_ch.coll_term_freq, len_reg[REG_COLL_LEN_TITLE], req_ch.doc_len_title));
            else
               body_acc = sat_sum(body_acc, log_ratio(req_ch.term_freq,
                  req_ch.coll_term_freq, len_reg[REG_COLL_LEN_BODY], req_ch.doc_len_body));
            whole_acc = sat_sum(whole_acc, log_ratio(req_ch.term_freq,
               req_ch.coll_term_freq, len_reg[REG_COLL_LEN_WHOLE], req_ch.doc_len_whole));
            if (pending_known.size() != 0 && pending_known.pop_front())
               want = pending_scores.pop_front();
            else begin
               want.title = title_acc;
               want.body  = body_acc;
               want.whole = whole_acc;
            end
            if (req_ch.last_term) begin
               expected_scores = {expected_scores, want};
               title_acc = '0;
               body_acc  = '0;
               whole_acc = '0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= !hold_rsp && ($urandom_range(99, 0) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tf_doclen_colltf_colllen_score: mismatch");
         $finish;
      end
   end

   task automatic send_term(term_type t, bit known = 1'b0,
                            scores_type s = '{default: 0});
      while ($urandom_range(99, 0) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      pending_known = {pending_known, known};
      if (known) pending_scores = {pending_scores, s};
      req_ch.valid          <= 1'b1;
      req_ch.term_freq      <= t.tf;
      req_ch.coll_term_freq <= t.ctf;
      req_ch.is_title       <= t.title;
      req_ch.doc_len_title  <= t.dl_title;
      req_ch.doc_len_body   <= t.dl_body;
      req_ch.doc_len_whole  <= t.dl_whole;
      req_ch.last_term      <= t.last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, bit [CL_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_A_W'(idx * 8);
      csr_pwdata  <= 64'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      len_reg[idx] = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_lengths(bit [CL_W-1:0] t, bit [CL_W-1:0] b, bit [CL_W-1:0] w);
      csr_write(REG_COLL_LEN_TITLE, t);
      csr_write(REG_COLL_LEN_BODY, b);
      csr_write(REG_COLL_LEN_WHOLE, w);
      @(posedge clock);
   endtask

   function automatic term_type random_term(bit last);
      term_type t;
      t.tf       = TF_W'(pick(TF_W));
      t.ctf      = CL_W'(pick(CL_W));
      t.title    = 1'($urandom_range(1, 0));
      t.dl_title = DL_W'(pick(DL_W));
      t.dl_body  = DL_W'(pick(DL_W));
      t.dl_whole = DL_W'(pick(DL_W));
      t.last     = last;
      return t;
   endfunction

   task automatic send_doc(int n);
      for (int i = 0; i < n; i++) send_term(random_term(i == n - 1));
   endtask

   function automatic void add_row(bit [TF_W-1:0] tf, bit [CL_W-1:0] ctf, bit title,
                                   bit [DL_W-1:0] dl, bit last, bit known);
      row_type r;
      r.term   = '{tf, ctf, title, dl, dl, dl, last};
      r.known  = known;
      r.scores = '{default: 0};
      rows = {rows, r};
   endfunction

   initial begin
      term_type t;
      int       sent;
      reset        = 1'b1;
      errors       = 0;
      hold_rsp     = 1'b0;
      quiet_cycles = 0;
      src_idle_pct = 36;
      snk_idle_pct = 55;
      title_acc = '0; body_acc = '0; whole_acc = '0;
      foreach (len_reg[i]) len_reg[i] = '0;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= '0;
      req_ch.valid <= 1'b0; req_ch.term_freq <= '0; req_ch.coll_term_freq <= '0;
      req_ch.is_title <= 1'b0; req_ch.doc_len_title <= '0; req_ch.doc_len_body <= '0;
      req_ch.doc_len_whole <= '0; req_ch.last_term <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lengths still zero after reset: every value is zero
      add_row('1, '1, 1'b1, '1, 1'b0, 1'b0);
      add_row('1, '0, 1'b0, '0, 1'b1, 1'b1);
      foreach (rows[i]) send_term(rows[i].term, rows[i].known, rows[i].scores);
      drain();
      rows.delete();

      set_lengths('1, 40'd1, '1);
      add_row('0, '1, 1'b1, '0, 1'b1, 1'b1);          // absent term
      add_row('1, '0, 1'b1, '0, 1'b0, 1'b0);          // zero collection frequency
      add_row('1, '0, 1'b0, '0, 1'b1, 1'b0);
      add_row('1, '1, 1'b1, '1, 1'b1, 1'b0);
      add_row(32'd1, '1, 1'b0, '1, 1'b1, 1'b0);
      add_row(32'd1, 40'd1, 1'b1, 32'd1, 1'b0, 1'b0);
      add_row(32'h8000_0000, 40'h80_0000_0000, 1'b0, 32'h5555_5555, 1'b0, 1'b0);
      add_row(32'h5555_5555, 40'h55_5555_5555, 1'b1, 32'hAAAA_AAAA, 1'b0, 1'b0);
      add_row(32'hAAAA_AAAA, 40'hAA_AAAA_AAAA, 1'b0, 32'h5555_5555, 1'b1, 1'b0);
      foreach (rows[i]) send_term(rows[i].term, rows[i].known, rows[i].scores);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         if (phase < 2) begin
            src_idle_pct = 36; snk_idle_pct = 55;
         end else if (phase < 4) begin
            src_idle_pct = 55; snk_idle_pct = 36;
         end else begin
            src_idle_pct = 0; snk_idle_pct = 0;
         end
         case (phase)
            0: set_lengths('0, '0, '0);
            4: set_lengths('1, '1, '1);
            default: set_lengths(CL_W'(pick(CL_W)), CL_W'(pick(CL_W)), CL_W'(pick(CL_W)));
         endcase
         if (phase == 2) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (LONG_HOLD) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         if (phase == 4) begin
            // enough large terms to drive every sum into saturation
            for (int i = 0; i < 200; i++) begin
               t = '{'1, '0, i[0], '0, '0, '0, i == 199};
               send_term(t);
            end
         end
         sent = 0;
         while (sent < 64) begin
            int n;
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
            send_doc(n);
            sent += n;
         end
         req_ch.valid <= 1'b0;
         drain();
      end

      if (errors == 0)
         $display("tf_doclen_colltf_colllen_score: match");
      else
         $display("tf_doclen_colltf_colllen_score: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tdcs_pkg.sv
hdl/tdcs_if.sv
hdl/tdcs_term_unit.sv
hdl/tf_doclen_colltf_colllen_score.sv
hdl/tdcs_chk.sv
test/tf_doclen_colltf_colllen_score_tb.sv
